// File: rtl/lts_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lts_pkg: shared types and constants of the lexical token scanner
// Scan modes, token kinds, error codes, keyword table and the
// controller/datapath command and status structs.
// ---------------------------------------------------------------------------
package lts_pkg;

  localparam int NUM_KW = 17;
  localparam int TEXT_DEPTH = 32;

  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_IDENT   = 4'd1;
  localparam logic [3:0] MODE_NUMBER  = 4'd2;
  localparam logic [3:0] MODE_AMP     = 4'd3;
  localparam logic [3:0] MODE_BAR     = 4'd4;
  localparam logic [3:0] MODE_REL     = 4'd5;
  localparam logic [3:0] MODE_SLASH   = 4'd6;
  localparam logic [3:0] MODE_COMMENT = 4'd7;
  localparam logic [3:0] MODE_CSTAR   = 4'd8;

  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_KEYW   = 3'd2;
  localparam logic [2:0] KIND_DELIM  = 3'd3;
  localparam logic [2:0] KIND_UNK    = 3'd4;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_UNK  = 3'd1;
  localparam logic [2:0] ERR_AMP  = 3'd2;
  localparam logic [2:0] ERR_BAR  = 3'd3;
  localparam logic [2:0] ERR_LONG = 3'd4;

  // Source of the characters of the token being emitted
  localparam logic [1:0] SRC_BUF   = 2'd0; // text buffer
  localparam logic [1:0] SRC_BYTE  = 2'd1; // held byte repeated
  localparam logic [1:0] SRC_PAIR  = 2'd2; // first char, then second char

  typedef struct packed {
    logic       start;      // load a token for emission
    logic [2:0] kind;
    logic [4:0] kw;
    logic [2:0] err;
    logic [1:0] src;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [5:0] len;
    logic       last;       // this token ends the transaction's results
  } emit_cmd_t;

  typedef struct packed {
    logic busy;             // token still being emitted
  } emit_sts_t;

  function automatic logic [5:0] kw_len(input int k);
    case (k)
      0: kw_len = 6'd5;  1: kw_len = 6'd4;  2: kw_len = 6'd4;  3: kw_len = 6'd8;
      4: kw_len = 6'd7;  5: kw_len = 6'd2;  6: kw_len = 6'd4;  7: kw_len = 6'd3;
      8: kw_len = 6'd8;  9: kw_len = 6'd2;  10: kw_len = 6'd3; 11: kw_len = 6'd4;
      12: kw_len = 6'd6; 13: kw_len = 6'd6; 14: kw_len = 6'd4; 15: kw_len = 6'd5;
      default: kw_len = 6'd5;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input int k, input int p);
    logic [63:0] w;   // keyword text, last character in the low byte
    int          n;
    case (k)
      0: w = 64'("break");     1: w = 64'("call");     2: w = 64'("case");
      3: w = 64'("continue");  4: w = 64'("default");  5: w = 64'("do");
      6: w = 64'("else");      7: w = 64'("for");      8: w = 64'("function");
      9: w = 64'("if");        10: w = 64'("int");     11: w = 64'("read");
      12: w = 64'("return");   13: w = 64'("switch");  14: w = 64'("void");
      15: w = 64'("while");
      default: w = 64'("write");
    endcase
    n = int'(kw_len(k));
    if (p < n) kw_char = w[8 * (n - 1 - p) +: 8];
    else kw_char = 8'd0;
  endfunction

endpackage
`default_nettype wire

// File: rtl/lts_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lts_datapath: token text buffer and result emitter
// Holds the token text memory and walks a loaded token out one character
// per cycle through a registered output stage, pausing while out_ready is low.
// ---------------------------------------------------------------------------
module lts_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [4:0]        wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire lts_pkg::emit_cmd_t cmd,
  input  wire logic [15:0]       line_count,
  input  wire logic [15:0]       error_total,
  output lts_pkg::emit_sts_t     sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             token_kind,
  output logic [4:0]             keyword_number,
  output logic [7:0]             text_char,
  output logic [4:0]             char_position,
  output logic                   token_end,
  output logic [2:0]             error_kind,
  output logic [15:0]            line_number,
  output logic [15:0]            errors_so_far,
  output logic                   last
);
  import lts_pkg::*;

  logic [7:0] text_mem [TEXT_DEPTH];
  logic [7:0] rd_data;
  logic [4:0] rd_addr;
  emit_cmd_t  cur;
  logic       active;
  logic [5:0] pos;        // index of the character held in rd_data
  logic       take;
  logic       present;    // load the output stage this cycle
  logic       final_char;

  assign sts.busy   = active;
  assign take       = out_valid && out_ready;
  assign present    = active && (!out_valid || take);
  assign final_char = (pos + 6'd1 == cur.len);

  // Read one ahead so rd_data always holds character pos
  always_comb begin
    if (cmd.start) rd_addr = 5'd0;
    else if (present) rd_addr = 5'(pos + 6'd1);
    else rd_addr = pos[4:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) text_mem[wr_addr] <= wr_data;
    rd_data <= text_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (cmd.start) begin
        cur    <= cmd;
        active <= 1'b1;
        pos    <= '0;
      end else if (present) begin
        active <= !final_char;
        pos    <= pos + 6'd1;
      end
      if (present) out_valid <= 1'b1;
      else if (take) out_valid <= 1'b0;
      if (present) begin
        token_kind     <= cur.kind;
        keyword_number <= cur.kw;
        error_kind     <= cur.err;
        line_number    <= line_count;
        errors_so_far  <= error_total;
        char_position  <= pos[4:0];
        token_end      <= final_char;
        last           <= final_char && cur.last;
        case (cur.src)
          SRC_BUF:  text_char <= rd_data;
          SRC_PAIR: text_char <= (pos == 6'd0) ? cur.c0 : cur.c1;
          default:  text_char <= cur.c0;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/lts_control.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lts_control: scan state machine
// Classifies each byte, updates mode, length, candidates and counters, and
// queues up to two tokens per transaction for the emitter.
// ---------------------------------------------------------------------------
module lts_control #(
  parameter int MAX_TOKEN = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         source_byte,
  input  wire logic               end_of_input,
  input  wire lts_pkg::emit_sts_t sts,
  output lts_pkg::emit_cmd_t      cmd,
  output logic                    wr_en,
  output logic [4:0]              wr_addr,
  output logic [7:0]              wr_data,
  output logic [15:0]             line_count,
  output logic [15:0]             error_total
);
  import lts_pkg::*;

  localparam int LIMIT = (MAX_TOKEN < TEXT_DEPTH) ? MAX_TOKEN : TEXT_DEPTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT1 = 2'd1;
  localparam logic [1:0] ST_WAIT2 = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]  state;
  logic [3:0]  mode;
  logic [5:0]  length;
  logic [16:0] cand;
  logic        trunc;
  logic [7:0]  rel_char;
  emit_cmd_t   pend;     // second token of this transaction
  logic        pend_v;
  emit_cmd_t   cmd_next;
  logic        emit_done;
  logic        nl_hold;   // newline that follows the flushed token
  logic        wr_hold;   // first char of a new token, written after flush
  logic [7:0]  hold_data;

  // Combinational scan of one byte
  logic [3:0]  mode_next;
  logic [5:0]  length_next;
  logic [16:0] cand_next;
  logic        trunc_next;
  logic        nl, err_inc;
  emit_cmd_t   t0, t1;
  logic        t0_v, t1_v, reidle;
  logic        is_let, is_dig, is_sgl, do_add, ident_add;
  logic [5:0]  add_pos;
  logic        in_wr;
  logic [7:0]  c;
  logic [4:0]  kw_hit;
  logic        kw_found;
  logic [7:0]  rel_next;
  logic        err2;

  always_comb begin
    c = source_byte;
    is_let = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    is_dig = c >= "0" && c <= "9";
    is_sgl = c == "+" || c == "-" || c == "*" || c == "(" || c == ")" ||
             c == "{" || c == "}" || c == ";" || c == "," || c == ":" ||
             c == "[" || c == "]";
    kw_found = 1'b0;
    kw_hit = '0;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && kw_len(k) == length) begin
        kw_found = 1'b1;
        kw_hit = 5'(k);
      end
    end
    mode_next = mode; length_next = length; cand_next = cand; trunc_next = trunc;
    rel_next = rel_char;
    nl = 1'b0; err_inc = 1'b0; err2 = 1'b0;
    t0 = '0; t1 = '0; t0_v = 1'b0; t1_v = 1'b0; reidle = 1'b0;
    do_add = 1'b0; ident_add = 1'b0; add_pos = length;
    // Flush token of the current mode into t0
    case (mode)
      MODE_IDENT: begin
        t0_v = 1'b1; t0.src = SRC_BUF; t0.len = length;
        if (trunc) begin t0.kind = KIND_IDENT; t0.err = ERR_LONG; end
        else if (kw_found) begin t0.kind = KIND_KEYW; t0.kw = kw_hit; end
        else t0.kind = KIND_IDENT;
      end
      MODE_NUMBER: begin t0_v = 1'b1; t0.src = SRC_BUF; t0.len = length;
        t0.kind = KIND_NUMBER; end
      MODE_AMP: begin t0_v = 1'b1; t0.src = SRC_BYTE; t0.len = 6'd1;
        t0.kind = KIND_DELIM; t0.err = ERR_AMP; t0.c0 = "&"; end
      MODE_BAR: begin t0_v = 1'b1; t0.src = SRC_BYTE; t0.len = 6'd1;
        t0.kind = KIND_DELIM; t0.err = ERR_BAR; t0.c0 = "|"; end
      MODE_REL: begin t0_v = 1'b1; t0.src = SRC_BYTE; t0.len = 6'd1;
        t0.kind = KIND_DELIM; t0.c0 = rel_char; end
      MODE_SLASH: begin t0_v = 1'b1; t0.src = SRC_BYTE; t0.len = 6'd1;
        t0.kind = KIND_DELIM; t0.c0 = "/"; end
      default: ;
    endcase
    err2 = (mode == MODE_AMP) || (mode == MODE_BAR);
    if (end_of_input) begin
      mode_next = MODE_IDLE;
      err_inc = err2;
      if (mode == MODE_COMMENT || mode == MODE_CSTAR) t0_v = 1'b0;
    end else begin
      case (mode)
        MODE_IDENT: if (is_let || is_dig) begin
          t0_v = 1'b0; do_add = 1'b1; ident_add = 1'b1; end else reidle = 1'b1;
        MODE_NUMBER: if (is_dig) begin t0_v = 1'b0; do_add = 1'b1; end
          else reidle = 1'b1;
        MODE_AMP, MODE_BAR:
          if ((mode == MODE_AMP && c == "&") || (mode == MODE_BAR && c == "|")) begin
            t0.src = SRC_BYTE; t0.len = 6'd2; t0.err = ERR_NONE;
            mode_next = MODE_IDLE;
          end else begin reidle = 1'b1; err_inc = 1'b1; end
        MODE_REL: if (c == "=") begin
            t0.src = SRC_PAIR; t0.len = 6'd2; t0.c1 = "="; mode_next = MODE_IDLE;
          end else reidle = 1'b1;
        MODE_SLASH: if (c == "*") begin t0_v = 1'b0; mode_next = MODE_COMMENT; end
          else reidle = 1'b1;
        MODE_COMMENT: begin
          if (c == "*") mode_next = MODE_CSTAR;
          else if (c == "\n") nl = 1'b1;
        end
        MODE_CSTAR: begin
          if (c == "/") mode_next = MODE_IDLE;
          else if (c != "*") begin nl = (c == "\n"); mode_next = MODE_COMMENT; end
        end
        default: reidle = 1'b1;
      endcase
      if (reidle) begin
        mode_next = MODE_IDLE;
        t1.kind = KIND_DELIM; t1.src = SRC_BYTE; t1.len = 6'd1; t1.c0 = c;
        if (c == " " || c == "\t") ;
        else if (c == "\n") nl = 1'b1;
        else if (is_let || is_dig) begin
          mode_next = is_let ? MODE_IDENT : MODE_NUMBER;
          length_next = '0; trunc_next = 1'b0; cand_next = '1;
          add_pos = '0; do_add = 1'b1; ident_add = is_let;
        end else if (is_sgl) t1_v = 1'b1;
        else if (c == "&") mode_next = MODE_AMP;
        else if (c == "|") mode_next = MODE_BAR;
        else if (c == "<" || c == ">" || c == "=" || c == "!") begin
          mode_next = MODE_REL; rel_next = c;
        end else if (c == "/") mode_next = MODE_SLASH;
        else begin t1_v = 1'b1; t1.kind = KIND_UNK; t1.err = ERR_UNK; end
      end
    end
    in_wr = 1'b0;
    if (do_add) begin
      if (add_pos < 6'(LIMIT)) begin
        in_wr = 1'b1;
        length_next = add_pos + 6'd1;
        if (ident_add) begin
          for (int k = 0; k < NUM_KW; k++)
            if (add_pos >= kw_len(k) || kw_char(k, int'(add_pos[3:0])) != c)
              cand_next[k] = 1'b0;
          if (add_pos >= 6'd9) cand_next = '0;
        end
      end else if (ident_add) trunc_next = 1'b1;
    end
  end

  // Emitter has taken the loaded token and shown its last character
  assign emit_done = !cmd.start && !sts.busy;

  // A new token's first char must not overwrite the text still being flushed
  assign in_ready = (state == ST_IDLE);
  assign wr_en = (in_valid && in_ready && in_wr && !t0_v) ||
                 (state == ST_EMIT1 && wr_hold && emit_done);
  assign wr_addr = wr_hold ? 5'd0 : add_pos[4:0];
  assign wr_data = wr_hold ? hold_data : c;

  logic [15:0] err_after_first;
  always_comb err_after_first = (err_inc && error_total != 16'hFFFF) ?
    error_total + 16'd1 : error_total;

  // Command register: start is a one-cycle pulse
  always_comb begin
    cmd_next = cmd;
    cmd_next.start = 1'b0;
    if (state == ST_IDLE && in_valid && t0_v) begin
      cmd_next = t0;
      cmd_next.start = 1'b1;
      cmd_next.last = !t1_v;
    end else if (state == ST_WAIT2) begin
      cmd_next = pend;
      cmd_next.start = 1'b1;
      cmd_next.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; mode <= MODE_IDLE; length <= '0; cand <= '1;
      trunc <= 1'b0; line_count <= 16'd1; error_total <= '0;
      pend_v <= 1'b0; cmd <= '0; nl_hold <= 1'b0; wr_hold <= 1'b0;
    end else begin
      cmd <= cmd_next;
      case (state)
        ST_IDLE: if (in_valid) begin
          mode <= mode_next; length <= length_next; cand <= cand_next;
          trunc <= trunc_next; rel_char <= rel_next;
          // a newline after a token counts only once that token is out
          if (nl && !t0_v && line_count != 16'hFFFF) line_count <= line_count + 16'd1;
          nl_hold <= nl && t0_v;
          wr_hold <= in_wr && t0_v;
          hold_data <= c;
          error_total <= err_after_first;
          pend <= t1;
          pend_v <= t1_v;
          if (t0_v) begin
            state <= ST_EMIT1;
          end else if (t1_v) begin
            state <= ST_WAIT2;
          end
        end
        ST_EMIT1: begin
          // First token loaded; wait until it has drained
          if (emit_done) begin
            state <= pend_v ? ST_WAIT2 : ST_DRAIN;
            if (nl_hold && line_count != 16'hFFFF) line_count <= line_count + 16'd1;
            nl_hold <= 1'b0;
            wr_hold <= 1'b0;
          end
        end
        ST_WAIT2: begin
          // Unknown-character error counts before its own token is shown
          if (pend.err == ERR_UNK && error_total != 16'hFFFF)
            error_total <= error_total + 16'd1;
          pend_v <= 1'b0;
          state <= ST_DRAIN;
        end
        default: if (emit_done) state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/lexical_token_scanner.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lexical_token_scanner: byte-serial lexer for a small test language
// Path: a byte's first token passes the controller's command register, the
// emitter's token register and its output stage; a lone delimiter or unknown
// character seen from idle waits in ST_WAIT2 first. in_ready is high only in
// idle, so a byte whose tokens are emitted holds off the next byte until they
// drain; the emitter shows one char per cycle while out_ready is high.
// Reset: synchronous; idle mode, line 1, zero errors, text memory unwritten.
// ---------------------------------------------------------------------------
module lexical_token_scanner #(
  parameter int MAX_TOKEN = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  source_byte,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       token_kind,
  output logic [4:0]       keyword_number,
  output logic [7:0]       text_char,
  output logic [4:0]       char_position,
  output logic             token_end,
  output logic [2:0]       error_kind,
  output logic [15:0]      line_number,
  output logic [15:0]      errors_so_far,
  output logic             last
);
  import lts_pkg::*;

  emit_cmd_t   cmd;
  emit_sts_t   sts;
  logic        wr_en;
  logic [4:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [15:0] line_count, error_total;

  // Controller: mode machine, counters and token sequencing
  lts_control #(.MAX_TOKEN(MAX_TOKEN)) u_ctl (
    .clk, .rst, .in_valid, .in_ready, .source_byte, .end_of_input,
    .sts, .cmd, .wr_en, .wr_addr, .wr_data, .line_count, .error_total
  );

  // Datapath: text memory and character emitter
  lts_datapath u_dp (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .cmd, .line_count, .error_total,
    .sts, .out_valid, .out_ready, .token_kind, .keyword_number, .text_char,
    .char_position, .token_end, .error_kind, .line_number, .errors_so_far, .last
  );
endmodule
`default_nettype wire
